// ----- hw/rtl/tcp_lite_connection_engine_assert.svh -----
// Assertion macros for the connection engine's top-level RTL file.
`ifndef TCP_LITE_CONNECTION_ENGINE_ASSERT_SVH
`define TCP_LITE_CONNECTION_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcp_lite_connection_engine: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcp_lite_connection_engine: next-cycle check failed");

`endif

// ----- hw/rtl/tle_pkg.sv -----
// Types, constants and codes shared by the connection engine modules.
`default_nettype none

package tle_pkg;

    // Field widths.
    localparam int SEQ_W      = 32;
    localparam int WIN_W      = 16;
    localparam int LEN_W      = 12;
    localparam int ISN_W      = 8;
    localparam int CS_W       = 4;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Segmentation and window limits.
    localparam logic [LEN_W-1:0] MAX_LEN      = LEN_W'(3072);
    localparam logic [LEN_W-1:0] SEND_WINDOW  = LEN_W'(3072);
    localparam logic [LEN_W-1:0] SEGMENT_SIZE = LEN_W'(536);

    // Configuration reset values.
    localparam logic [ISN_W-1:0] ISN_RESET    = ISN_W'(1);
    localparam logic             ACTIVE_RESET = 1'b1;
    localparam logic [WIN_W-1:0] ADV_RESET    = WIN_W'(3072);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEQUENCE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_OPEN       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ADVERTISED_WINDOW = CFG_IDX_W'(2);

    // Event codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_OPEN    = 2'd0,
        REQ_SEGMENT = 2'd1,
        REQ_DATA    = 2'd2,
        REQ_CLOSE   = 2'd3
    } req_t;

    // Connection states, densely numbered.
    typedef enum logic [CS_W-1:0] {
        CS_IDLE       = 4'd0,
        CS_LISTEN     = 4'd1,
        CS_SYN_SENT   = 4'd2,
        CS_SYN_RCVD   = 4'd3,
        CS_ESTAB      = 4'd4,
        CS_FIN_WAIT1  = 4'd5,
        CS_FIN_WAIT2  = 4'd6,
        CS_CLOSE_WAIT = 4'd7,
        CS_LAST_ACK   = 4'd8,
        CS_CLOSED     = 4'd9
    } conn_state_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        CTL_WAIT,
        CTL_CALC,
        CTL_APPLY,
        CTL_EMIT
    } ctrl_state_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic capture;
        logic calc;
        logic apply;
        logic emit;
    } tle_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic any_pend;
        logic out_free;
    } tle_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcp_lite_connection_engine.sv -----
// Top level of the simplified TCP connection header engine.
//
//  Channel   Handshake            Direction  Carries
//  in        in_valid / in_stall  in         one event: open, segment, data, close
//  out       out_valid/ out_stall out        one header or application delivery
//  cfg       cfg_we               in         initial sequence, open mode, window
//
// An event causes 0 to 6 results. The sequencer steps it through capture,
// compare and state update, emits its results one by one, then returns.
// The sequencer handles one event at a time; results leave through a single
// output register, so the next event is taken while the last result waits.
// A stall on the output holds the sequencer in its emit step.
// rst_n clears the connection to idle and loads the configuration defaults.
`default_nettype none

module tcp_lite_connection_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration
    input  wire logic                          cfg_we,
    input  wire logic [tle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tle_pkg::CFG_DATA_W-1:0] cfg_data,
    // Event channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [tle_pkg::REQ_W-1:0]     req_type,
    input  wire logic                          in_syn,
    input  wire logic                          in_ack_flag,
    input  wire logic                          in_fin,
    input  wire logic [tle_pkg::SEQ_W-1:0]     in_seq,
    input  wire logic [tle_pkg::SEQ_W-1:0]     in_ack_number,
    input  wire logic [tle_pkg::WIN_W-1:0]     in_window,
    input  wire logic [tle_pkg::LEN_W-1:0]     byte_count,
    // Result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               out_kind,
    output logic                               out_syn,
    output logic                               out_ack_flag,
    output logic                               out_fin,
    output logic [tle_pkg::SEQ_W-1:0]          out_seq,
    output logic [tle_pkg::SEQ_W-1:0]          out_ack_number,
    output logic [tle_pkg::WIN_W-1:0]          out_window,
    output logic [tle_pkg::LEN_W-1:0]          out_length,
    output logic [tle_pkg::CS_W-1:0]           conn_state_out,
    output logic                               refused,
    output logic                               closed_done,
    output logic                               last
);
    import tle_pkg::*;

    tle_cmd_t    cmd;
    tle_status_t status;

    // Sequencer.
    tle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    tle_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_type       (req_type),
        .in_syn         (in_syn),
        .in_ack_flag    (in_ack_flag),
        .in_fin         (in_fin),
        .in_seq         (in_seq),
        .in_ack_number  (in_ack_number),
        .in_window      (in_window),
        .byte_count     (byte_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_kind       (out_kind),
        .out_syn        (out_syn),
        .out_ack_flag   (out_ack_flag),
        .out_fin        (out_fin),
        .out_seq        (out_seq),
        .out_ack_number (out_ack_number),
        .out_window     (out_window),
        .out_length     (out_length),
        .conn_state_out (conn_state_out),
        .refused        (refused),
        .closed_done    (closed_done),
        .last           (last)
    );

    // Checks on the engine's own logic.
`include "tcp_lite_connection_engine_assert.svh"

    // A new event is only taken once every result of the previous one has been emitted.
    `TLE_ASSERT_NOW(a_no_pend_on_accept, in_valid && !in_stall, !status.any_pend)
    // After a transfer in, the engine is busy for the compare step.
    `TLE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall && cmd.calc)
    // A finished connection only ever reports the closed state.
    `TLE_ASSERT_NOW(a_done_is_closed, out_valid && closed_done,
                    conn_state_out == CS_CLOSED)
    // A refusal is an empty delivery on a closed connection.
    `TLE_ASSERT_NOW(a_refused_shape, out_valid && refused,
                    out_kind && (out_length == '0) && closed_done && last)

endmodule

`default_nettype wire

// ----- hw/rtl/tle_ctrl.sv -----
// Sequencer that steps each event through capture, compare, update and emit.
`default_nettype none

module tle_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  tle_pkg::tle_status_t    status,
    output tle_pkg::tle_cmd_t       cmd
);
    import tle_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_WAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        unique case (state_reg)
            CTL_WAIT:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = CTL_CALC;
                end
            end
            CTL_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = CTL_APPLY;
            end
            CTL_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = CTL_EMIT;
            end
            CTL_EMIT:
            begin
                if (!status.any_pend)
                begin
                    state_next = CTL_WAIT;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tle_dp.sv -----
// Connection datapath: state registers, event evaluation and result register.
`default_nettype none

module tle_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  tle_pkg::tle_cmd_t                  cmd,
    output tle_pkg::tle_status_t               status,
    // Configuration
    input  wire logic                          cfg_we,
    input  wire logic [tle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tle_pkg::CFG_DATA_W-1:0] cfg_data,
    // Event fields
    input  wire logic [tle_pkg::REQ_W-1:0]     req_type,
    input  wire logic                          in_syn,
    input  wire logic                          in_ack_flag,
    input  wire logic                          in_fin,
    input  wire logic [tle_pkg::SEQ_W-1:0]     in_seq,
    input  wire logic [tle_pkg::SEQ_W-1:0]     in_ack_number,
    input  wire logic [tle_pkg::WIN_W-1:0]     in_window,
    input  wire logic [tle_pkg::LEN_W-1:0]     byte_count,
    // Result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               out_kind,
    output logic                               out_syn,
    output logic                               out_ack_flag,
    output logic                               out_fin,
    output logic [tle_pkg::SEQ_W-1:0]          out_seq,
    output logic [tle_pkg::SEQ_W-1:0]          out_ack_number,
    output logic [tle_pkg::WIN_W-1:0]          out_window,
    output logic [tle_pkg::LEN_W-1:0]          out_length,
    output logic [tle_pkg::CS_W-1:0]           conn_state_out,
    output logic                               refused,
    output logic                               closed_done,
    output logic                               last
);
    import tle_pkg::*;

    // Configuration registers.
    logic [ISN_W-1:0] isn_reg;
    logic             active_open_reg;
    logic [WIN_W-1:0] adv_window_reg;

    // Connection state.
    conn_state_t      conn_state_reg, conn_state_next;
    logic [SEQ_W-1:0] send_next_reg, send_next_next;
    logic [SEQ_W-1:0] acked_reg, acked_next;
    logic [SEQ_W-1:0] peer_seq_reg, peer_seq_next;
    logic [WIN_W-1:0] peer_win_reg, peer_win_next;
    logic [SEQ_W-1:0] fin_mark_reg, fin_mark_next;
    logic             finished_reg, finished_next;

    // Captured event.
    req_t             req_reg;
    logic             syn_reg;
    logic             ackf_reg;
    logic             fin_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic [SEQ_W-1:0] ackn_reg;
    logic [WIN_W-1:0] win_reg;
    logic [LEN_W-1:0] cnt_reg;

    // Compare stage results.
    logic             ack_in_range_reg;
    logic             ack_eq_fin_reg;
    logic             ack_eq_snd_reg;
    logic [SEQ_W-1:0] seq_next_reg;
    logic [SEQ_W-1:0] seq_plus1_reg;
    logic [LEN_W-1:0] room_reg;

    // Pending results of the current event.
    logic             dlv_pend_reg, dlv_pend_next;
    logic [LEN_W-1:0] dlv_len_reg, dlv_len_next;
    logic             dlv_refused_reg, dlv_refused_next;
    logic             hdr_pend_reg, hdr_pend_next;
    logic             hdr_syn_reg, hdr_syn_next;
    logic             hdr_ack_reg, hdr_ack_next;
    logic             hdr_fin_reg, hdr_fin_next;
    logic [SEQ_W-1:0] hdr_seq_reg, hdr_seq_next;
    logic [SEQ_W-1:0] hdr_ackn_reg, hdr_ackn_next;
    logic [LEN_W-1:0] seg_rem_reg, seg_rem_next;

    // Result register.
    logic             out_valid_reg, out_valid_next;
    logic             o_kind_reg;
    logic             o_syn_reg;
    logic             o_ack_reg;
    logic             o_fin_reg;
    logic [SEQ_W-1:0] o_seq_reg;
    logic [SEQ_W-1:0] o_ackn_reg;
    logic [WIN_W-1:0] o_win_reg;
    logic [LEN_W-1:0] o_len_reg;
    logic             o_refused_reg;
    logic             o_last_reg;

    // Combinational helpers.
    logic [LEN_W-1:0] len_clip;
    logic [SEQ_W-1:0] isn_full;
    logic [SEQ_W-1:0] flight;
    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] room;
    conn_state_t      sync_base;
    conn_state_t      st_after_ack;
    conn_state_t      st_after_fin;
    logic             fin_by_ack;
    logic             sync_takes;
    logic             sync_ok;
    logic [LEN_W-1:0] piece;

    assign len_clip = (cnt_reg > MAX_LEN) ? MAX_LEN : cnt_reg;
    assign isn_full = SEQ_W'(isn_reg);

    // Send room left in the window.
    assign flight = send_next_reg - acked_reg;
    assign limit  = (peer_win_reg < WIN_W'(SEND_WINDOW)) ? peer_win_reg[LEN_W-1:0]
                                                          : SEND_WINDOW;
    assign room   = (flight >= SEQ_W'(limit)) ? '0 : (limit - flight[LEN_W-1:0]);

    // Synchronized segment handling: ack first, then data and FIN.
    assign sync_base = (conn_state_reg == CS_SYN_RCVD) ? CS_ESTAB : conn_state_reg;
    assign sync_ok   = (conn_state_reg != CS_SYN_RCVD) || (ackf_reg && ack_eq_snd_reg);

    always_comb
    begin
        st_after_ack = sync_base;
        fin_by_ack   = 1'b0;
        if (ackf_reg && ack_eq_fin_reg)
        begin
            if (sync_base == CS_FIN_WAIT1)
            begin
                st_after_ack = CS_FIN_WAIT2;
            end
            else if (sync_base == CS_LAST_ACK)
            begin
                st_after_ack = CS_CLOSED;
                fin_by_ack   = 1'b1;
            end
        end
    end

    assign sync_takes = ((st_after_ack == CS_ESTAB) || (st_after_ack == CS_FIN_WAIT1) ||
                         (st_after_ack == CS_FIN_WAIT2)) &&
                        ((len_clip != '0) || fin_reg);

    always_comb
    begin
        st_after_fin = st_after_ack;
        if (sync_takes && fin_reg)
        begin
            if (st_after_ack == CS_ESTAB)
            begin
                st_after_fin = CS_CLOSE_WAIT;
            end
            else if (st_after_ack == CS_FIN_WAIT1)
            begin
                st_after_fin = CS_LAST_ACK;
            end
            else
            begin
                st_after_fin = CS_CLOSED;
            end
        end
    end

    assign piece = (seg_rem_reg > SEGMENT_SIZE) ? SEGMENT_SIZE : seg_rem_reg;

    // Status to the sequencer.
    assign status.any_pend = dlv_pend_reg || hdr_pend_reg || (seg_rem_reg != '0);
    assign status.out_free = !out_valid_reg || !out_stall;

    // Event update and result emission.
    always_comb
    begin
        conn_state_next  = conn_state_reg;
        send_next_next   = send_next_reg;
        acked_next       = acked_reg;
        peer_seq_next    = peer_seq_reg;
        peer_win_next    = peer_win_reg;
        fin_mark_next    = fin_mark_reg;
        finished_next    = finished_reg;
        dlv_pend_next    = dlv_pend_reg;
        dlv_len_next     = dlv_len_reg;
        dlv_refused_next = dlv_refused_reg;
        hdr_pend_next    = hdr_pend_reg;
        hdr_syn_next     = hdr_syn_reg;
        hdr_ack_next     = hdr_ack_reg;
        hdr_fin_next     = hdr_fin_reg;
        hdr_seq_next     = hdr_seq_reg;
        hdr_ackn_next    = hdr_ackn_reg;
        seg_rem_next     = seg_rem_reg;

        if (cmd.apply)
        begin
            dlv_pend_next    = 1'b0;
            dlv_len_next     = '0;
            dlv_refused_next = 1'b0;
            hdr_pend_next    = 1'b0;
            hdr_syn_next     = 1'b0;
            hdr_ack_next     = 1'b0;
            hdr_fin_next     = 1'b0;
            hdr_seq_next     = send_next_reg;
            hdr_ackn_next    = '0;
            seg_rem_next     = '0;
            unique case (req_reg)
                REQ_OPEN:
                begin
                    if (conn_state_reg == CS_IDLE)
                    begin
                        send_next_next = isn_full;
                        acked_next     = isn_full;
                        if (active_open_reg)
                        begin
                            hdr_pend_next   = 1'b1;
                            hdr_syn_next    = 1'b1;
                            hdr_seq_next    = isn_full;
                            send_next_next  = isn_full + SEQ_W'(1);
                            conn_state_next = CS_SYN_SENT;
                        end
                        else
                        begin
                            conn_state_next = CS_LISTEN;
                        end
                    end
                end
                REQ_SEGMENT:
                begin
                    unique case (conn_state_reg)
                        CS_SYN_SENT:
                        begin
                            if (syn_reg && ackf_reg && ack_eq_snd_reg)
                            begin
                                acked_next      = ackn_reg;
                                peer_seq_next   = seq_plus1_reg;
                                peer_win_next   = win_reg;
                                conn_state_next = CS_ESTAB;
                                hdr_pend_next   = 1'b1;
                                hdr_ack_next    = 1'b1;
                                hdr_ackn_next   = seq_plus1_reg;
                            end
                            else
                            begin
                                conn_state_next  = CS_CLOSED;
                                finished_next    = 1'b1;
                                dlv_pend_next    = 1'b1;
                                dlv_refused_next = 1'b1;
                            end
                        end
                        CS_LISTEN:
                        begin
                            if (syn_reg)
                            begin
                                peer_seq_next   = seq_plus1_reg;
                                peer_win_next   = win_reg;
                                conn_state_next = CS_SYN_RCVD;
                                hdr_pend_next   = 1'b1;
                                hdr_syn_next    = 1'b1;
                                hdr_ack_next    = 1'b1;
                                hdr_ackn_next   = seq_plus1_reg;
                                send_next_next  = send_next_reg + SEQ_W'(1);
                            end
                            else
                            begin
                                conn_state_next  = CS_CLOSED;
                                finished_next    = 1'b1;
                                dlv_pend_next    = 1'b1;
                                dlv_refused_next = 1'b1;
                            end
                        end
                        CS_SYN_RCVD, CS_ESTAB, CS_FIN_WAIT1, CS_FIN_WAIT2,
                        CS_CLOSE_WAIT, CS_LAST_ACK:
                        begin
                            if (sync_ok)
                            begin
                                peer_win_next = win_reg;
                                if (ackf_reg && ack_in_range_reg)
                                begin
                                    acked_next = ackn_reg;
                                end
                                conn_state_next = st_after_fin;
                                if (fin_by_ack || (sync_takes && fin_reg &&
                                                   (st_after_ack == CS_FIN_WAIT2)))
                                begin
                                    finished_next = 1'b1;
                                end
                                if (sync_takes)
                                begin
                                    peer_seq_next = seq_next_reg;
                                    dlv_pend_next = (len_clip != '0);
                                    dlv_len_next  = len_clip;
                                    hdr_pend_next = 1'b1;
                                    hdr_ack_next  = 1'b1;
                                    hdr_ackn_next = seq_next_reg;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                REQ_DATA:
                begin
                    if ((conn_state_reg == CS_ESTAB) || (conn_state_reg == CS_CLOSE_WAIT))
                    begin
                        seg_rem_next = (len_clip > room_reg) ? room_reg : len_clip;
                    end
                end
                REQ_CLOSE:
                begin
                    if ((conn_state_reg == CS_LISTEN) || (conn_state_reg == CS_SYN_SENT))
                    begin
                        conn_state_next = CS_CLOSED;
                        finished_next   = 1'b1;
                    end
                    else if ((conn_state_reg == CS_ESTAB) ||
                             (conn_state_reg == CS_CLOSE_WAIT))
                    begin
                        hdr_pend_next   = 1'b1;
                        hdr_ack_next    = 1'b1;
                        hdr_fin_next    = 1'b1;
                        hdr_ackn_next   = peer_seq_reg;
                        send_next_next  = send_next_reg + SEQ_W'(1);
                        fin_mark_next   = send_next_reg + SEQ_W'(1);
                        conn_state_next = (conn_state_reg == CS_ESTAB) ? CS_FIN_WAIT1
                                                                       : CS_LAST_ACK;
                    end
                end
            endcase
        end
        else if (cmd.emit)
        begin
            // Delivery first, then the reply header, then data segments.
            if (dlv_pend_reg)
            begin
                dlv_pend_next = 1'b0;
            end
            else if (hdr_pend_reg)
            begin
                hdr_pend_next = 1'b0;
            end
            else
            begin
                send_next_next = send_next_reg + SEQ_W'(piece);
                seg_rem_next   = seg_rem_reg - piece;
            end
        end
    end

    // Result register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isn_reg         <= ISN_RESET;
            active_open_reg <= ACTIVE_RESET;
            adv_window_reg  <= ADV_RESET;
            conn_state_reg  <= CS_IDLE;
            send_next_reg   <= SEQ_W'(ISN_RESET);
            acked_reg       <= SEQ_W'(ISN_RESET);
            peer_seq_reg    <= '0;
            peer_win_reg    <= '0;
            fin_mark_reg    <= '0;
            finished_reg    <= 1'b0;
            dlv_pend_reg    <= 1'b0;
            hdr_pend_reg    <= 1'b0;
            seg_rem_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_INITIAL_SEQUENCE:  isn_reg         <= cfg_data[ISN_W-1:0];
                    CFG_ACTIVE_OPEN:       active_open_reg <= cfg_data[0];
                    CFG_ADVERTISED_WINDOW: adv_window_reg  <= cfg_data[WIN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            conn_state_reg <= conn_state_next;
            send_next_reg  <= send_next_next;
            acked_reg      <= acked_next;
            peer_seq_reg   <= peer_seq_next;
            peer_win_reg   <= peer_win_next;
            fin_mark_reg   <= fin_mark_next;
            finished_reg   <= finished_next;
            dlv_pend_reg   <= dlv_pend_next;
            hdr_pend_reg   <= hdr_pend_next;
            seg_rem_reg    <= seg_rem_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers: captured event, compare results and pending result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_t'(req_type);
            syn_reg  <= in_syn;
            ackf_reg <= in_ack_flag;
            fin_reg  <= in_fin;
            seq_reg  <= in_seq;
            ackn_reg <= in_ack_number;
            win_reg  <= in_window;
            cnt_reg  <= byte_count;
        end
        if (cmd.calc)
        begin
            ack_in_range_reg <= (ackn_reg - acked_reg) <= flight;
            ack_eq_fin_reg   <= (ackn_reg == fin_mark_reg);
            ack_eq_snd_reg   <= (ackn_reg == send_next_reg);
            seq_next_reg     <= seq_reg + SEQ_W'(len_clip) + SEQ_W'(fin_reg);
            seq_plus1_reg    <= seq_reg + SEQ_W'(1);
            room_reg         <= room;
        end
        dlv_len_reg     <= dlv_len_next;
        dlv_refused_reg <= dlv_refused_next;
        hdr_syn_reg     <= hdr_syn_next;
        hdr_ack_reg     <= hdr_ack_next;
        hdr_fin_reg     <= hdr_fin_next;
        hdr_seq_reg     <= hdr_seq_next;
        hdr_ackn_reg    <= hdr_ackn_next;
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (dlv_pend_reg)
            begin
                o_kind_reg    <= 1'b1;
                o_syn_reg     <= 1'b0;
                o_ack_reg     <= 1'b0;
                o_fin_reg     <= 1'b0;
                o_seq_reg     <= '0;
                o_ackn_reg    <= '0;
                o_win_reg     <= '0;
                o_len_reg     <= dlv_len_reg;
                o_refused_reg <= dlv_refused_reg;
                o_last_reg    <= !hdr_pend_reg && (seg_rem_reg == '0);
            end
            else if (hdr_pend_reg)
            begin
                o_kind_reg    <= 1'b0;
                o_syn_reg     <= hdr_syn_reg;
                o_ack_reg     <= hdr_ack_reg;
                o_fin_reg     <= hdr_fin_reg;
                o_seq_reg     <= hdr_seq_reg;
                o_ackn_reg    <= hdr_ackn_reg;
                o_win_reg     <= adv_window_reg;
                o_len_reg     <= '0;
                o_refused_reg <= 1'b0;
                o_last_reg    <= (seg_rem_reg == '0);
            end
            else
            begin
                o_kind_reg    <= 1'b0;
                o_syn_reg     <= 1'b0;
                o_ack_reg     <= 1'b1;
                o_fin_reg     <= 1'b0;
                o_seq_reg     <= send_next_reg;
                o_ackn_reg    <= peer_seq_reg;
                o_win_reg     <= adv_window_reg;
                o_len_reg     <= piece;
                o_refused_reg <= 1'b0;
                o_last_reg    <= (seg_rem_reg == piece);
            end
        end
    end

    // The state fields of a result always show the state after the whole event.
    logic [CS_W-1:0] o_state_reg;
    logic            o_done_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_state_reg <= conn_state_reg;
            o_done_reg  <= finished_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_kind       = o_kind_reg;
    assign out_syn        = o_syn_reg;
    assign out_ack_flag   = o_ack_reg;
    assign out_fin        = o_fin_reg;
    assign out_seq        = o_seq_reg;
    assign out_ack_number = o_ackn_reg;
    assign out_window     = o_win_reg;
    assign out_length     = o_len_reg;
    assign conn_state_out = o_state_reg;
    assign refused        = o_refused_reg;
    assign closed_done    = o_done_reg;
    assign last           = o_last_reg;

endmodule

`default_nettype wire
